>>> rtl/spf_pkg.sv
// spf_pkg: shared types and constant tables for the sensitive path filter
// holds the prefix rule strings, the tail patterns and the verdict codes
// no dependencies
`default_nettype none

package spf_pkg;

	localparam int RULE_COUNT   = 8;
	localparam int RULE_MAX_LEN = 18;
	localparam int WINDOW_LEN   = 17;
	localparam int RELEASE_LEN  = 13;
	localparam int NOTIFY_LEN   = 17;
	localparam int LEN_SAT      = 255;

	// the first rule also takes this character at this place (/etc/p)
	localparam int           RULE0_ALT_POS  = 5;
	localparam logic [7:0]   RULE0_ALT_CHAR = 8'h70;
	localparam logic [7:0]   PAD_CHAR       = 8'h20;

	typedef logic [0:RULE_MAX_LEN-1][7:0] rule_str_t;
	typedef logic [4:0]                   rule_len_t;
	typedef logic [WINDOW_LEN-1:0][7:0]   window_t;
	typedef logic [0:RELEASE_LEN-1][7:0]  release_str_t;
	typedef logic [0:NOTIFY_LEN-1][7:0]   notify_str_t;

	localparam rule_str_t RULE_TEXT [RULE_COUNT] = '{
		{"/etc/s",             {12{PAD_CHAR}}},
		{"/proc/k",            {11{PAD_CHAR}}},
		{"/var/run/d",         {8{PAD_CHAR}}},
		{"/run/d",             {12{PAD_CHAR}}},
		{"/proc/self/exe",     {4{PAD_CHAR}}},
		{"/proc/self/mem",     {4{PAD_CHAR}}},
		"/proc/self/cmdline",
		{"/host_",             {12{PAD_CHAR}}}
	};

	localparam rule_len_t RULE_LEN [RULE_COUNT] = '{
		5'd6, 5'd7, 5'd10, 5'd6, 5'd14, 5'd14, 5'd18, 5'd6
	};

	localparam release_str_t RELEASE_TEXT = {"release", "_agent"};
	localparam notify_str_t  NOTIFY_TEXT  = {"notify_on", "_release"};

	typedef enum logic [1:0] {
		HIT_NONE    = 2'd0,
		HIT_PREFIX  = 2'd1,
		HIT_RELEASE = 2'd2,
		HIT_NOTIFY  = 2'd3
	} hit_kind_t;

	typedef struct packed {
		logic      report;
		hit_kind_t kind;
	} verdict_t;

endpackage

`default_nettype wire

>>> rtl/spf_scan.sv
// spf_scan: per-word next-state and verdict logic of the sensitive path filter
// updates the prefix flags, the tail window and the count for one character
// depends on spf_pkg
`default_nettype none

module spf_scan import spf_pkg::*; #(
	parameter int MAX_PATH_CHARS = 255,
	parameter int PW             = $clog2(MAX_PATH_CHARS + 1)
) (
	input  wire logic [PW-1:0]         position,
	input  wire logic [RULE_COUNT-1:0] prefix_alive,
	input  wire logic                  string_ended,
	input  wire window_t               tail_window,
	input  wire logic [7:0]            path_byte,
	input  wire logic [1:0]            access_mode,
	output logic [PW-1:0]              position_nx,
	output logic [RULE_COUNT-1:0]      prefix_alive_nx,
	output logic                       string_ended_nx,
	output window_t                    tail_window_nx,
	output verdict_t                   verdict,
	output logic [7:0]                 path_length
);

	localparam int LW = (PW > 8) ? PW : 8;

	logic            keep;
	logic [4:0]      char_idx;
	logic            prefix_hit;
	logic            release_hit;
	logic            notify_hit;
	logic [LW-1:0]   pos_ext;

	assign keep = !string_ended && (path_byte != 8'h00) &&
		(position < PW'(MAX_PATH_CHARS));
	assign char_idx = (position < PW'(RULE_MAX_LEN)) ? position[4:0] : 5'd0;
	assign string_ended_nx = string_ended || (path_byte == 8'h00);
	assign position_nx = keep ? position + PW'(1) : position;

	always_comb begin
		for (int r = 0; r < RULE_COUNT; r++) begin
			prefix_alive_nx[r] = prefix_alive[r];
			if (keep && (position < PW'(RULE_LEN[r]))) begin
				if (!((path_byte == RULE_TEXT[r][char_idx]) ||
					((r == 0) && (position == PW'(RULE0_ALT_POS)) &&
					(path_byte == RULE0_ALT_CHAR)))) begin
					prefix_alive_nx[r] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		if (keep) begin
			tail_window_nx = {path_byte, tail_window[WINDOW_LEN-1:1]};
		end else begin
			tail_window_nx = tail_window;
		end
	end

	always_comb begin
		prefix_hit = 1'b0;
		for (int r = 0; r < RULE_COUNT; r++) begin
			if (prefix_alive_nx[r] && (position_nx >= PW'(RULE_LEN[r]))) begin
				prefix_hit = 1'b1;
			end
		end
	end

	// window slot 0 holds the oldest character
	always_comb begin
		release_hit = position_nx >= PW'(RELEASE_LEN);
		for (int k = 0; k < RELEASE_LEN; k++) begin
			if (tail_window_nx[WINDOW_LEN-RELEASE_LEN+k] != RELEASE_TEXT[k]) begin
				release_hit = 1'b0;
			end
		end
	end

	always_comb begin
		notify_hit = position_nx >= PW'(NOTIFY_LEN);
		for (int k = 0; k < NOTIFY_LEN; k++) begin
			if (tail_window_nx[WINDOW_LEN-NOTIFY_LEN+k] != NOTIFY_TEXT[k]) begin
				notify_hit = 1'b0;
			end
		end
	end

	always_comb begin
		verdict.report = 1'b1;
		if (prefix_hit) begin
			verdict.kind = HIT_PREFIX;
		end else if ((access_mode != 2'd0) && release_hit) begin
			verdict.kind = HIT_RELEASE;
		end else if ((access_mode != 2'd0) && notify_hit) begin
			verdict.kind = HIT_NOTIFY;
		end else begin
			verdict.kind   = HIT_NONE;
			verdict.report = 1'b0;
		end
	end

	assign pos_ext = LW'(position_nx);
	assign path_length = (pos_ext > LW'(LEN_SAT)) ? 8'(LEN_SAT) : pos_ext[7:0];

endmodule

`default_nettype wire

>>> rtl/sensitive_path_filter.sv
// sensitive_path_filter: screens a byte-serial file path against sensitive locations
// input register, path state registers and result register around spf_scan
// depends on spf_pkg and spf_scan
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------
//   in      | in_valid / in_ready  | path_byte, is_last, access_mode
//   out     | out_valid / out_ready| report, hit_kind, path_length
//
// one word per cycle when no last word stalls; a verdict waits in the result register
// the path state moves as a word leaves the input register, set by spf_scan
// reset clears the path state and both valid flags
// a waiting verdict stalls only the next last word; other words keep flowing
`default_nettype none

module sensitive_path_filter import spf_pkg::*; #(
	parameter int MAX_PATH_CHARS = 255
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] path_byte,
	input  wire logic       is_last,
	input  wire logic [1:0] access_mode,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            report,
	output logic [1:0]      hit_kind,
	output logic [7:0]      path_length
);

	localparam int PW = $clog2(MAX_PATH_CHARS + 1);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;
	logic [1:0]            mode_s1;

	logic [PW-1:0]         position_q;
	logic [RULE_COUNT-1:0] prefix_alive_q;
	logic                  string_ended_q;
	window_t               tail_window_q;

	logic [PW-1:0]         position_nx;
	logic [RULE_COUNT-1:0] prefix_alive_nx;
	logic                  string_ended_nx;
	window_t               tail_window_nx;
	verdict_t              verdict;
	logic [7:0]            length_nx;

	logic                  out_valid_q;
	verdict_t              verdict_q;
	logic [7:0]            length_q;
	logic                  advance;

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= path_byte;
			last_s1 <= is_last;
			mode_s1 <= access_mode;
		end
	end

	spf_scan #(
		.MAX_PATH_CHARS(MAX_PATH_CHARS),
		.PW(PW)
	) u_scan (
		.position(position_q),
		.prefix_alive(prefix_alive_q),
		.string_ended(string_ended_q),
		.tail_window(tail_window_q),
		.path_byte(byte_s1),
		.access_mode(mode_s1),
		.position_nx(position_nx),
		.prefix_alive_nx(prefix_alive_nx),
		.string_ended_nx(string_ended_nx),
		.tail_window_nx(tail_window_nx),
		.verdict(verdict),
		.path_length(length_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q     <= '0;
			prefix_alive_q <= '1;
			string_ended_q <= 1'b0;
			tail_window_q  <= '0;
		end else if (advance) begin
			if (last_s1) begin
				position_q     <= '0;
				prefix_alive_q <= '1;
				string_ended_q <= 1'b0;
				tail_window_q  <= '0;
			end else begin
				position_q     <= position_nx;
				prefix_alive_q <= prefix_alive_nx;
				string_ended_q <= string_ended_nx;
				tail_window_q  <= tail_window_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			verdict_q <= verdict;
			length_q  <= length_nx;
		end
	end

	assign out_valid   = out_valid_q;
	assign report      = verdict_q.report;
	assign hit_kind    = verdict_q.kind;
	assign path_length = length_q;

endmodule

`default_nettype wire

>>> tb/spf_checker.sv
// spf_checker: watches both channels of sensitive_path_filter, predicts each verdict word
// from the accepted path bytes and compares it field by field with the block's output
// depends on spf_pkg for the hit kind codes
`default_nettype none

module spf_checker import spf_pkg::*; #(
	parameter int MAX_KEPT = 255
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic [7:0] path_byte,
	input  wire logic       is_last,
	input  wire logic [1:0] access_mode,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic       report,
	input  wire logic [1:0] hit_kind,
	input  wire logic [7:0] path_length,
	output int              fail_count,
	output int              verdicts_waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TAIL_DEPTH = 17;

	typedef struct packed {
		logic       report;
		hit_kind_t  kind;
		logic [7:0] length;
	} path_verdict_t;

	string prefix_rules [8] = '{"/etc/s", "/proc/k", "/var/run/d", "/run/d",
		"/proc/self/exe", "/proc/self/mem", "/proc/self/cmdline", "/host_"};
	string tail_pats [2] = '{{"release", "_agent"}, {"notify_on", "_release"}};

	path_verdict_t verdict_q [$];
	path_verdict_t want;
	int            failures = 0;
	int            pending = 0;
	int            kept;
	logic [7:0]    alive;
	logic [7:0]    recent [TAIL_DEPTH];
	bit            ended;

	assign fail_count       = failures;
	assign verdicts_waiting = pending;

	task automatic clear_path();
		kept = 0;
		alive = '1;
		ended = 0;
		foreach (recent[i])
			recent[i] = 8'h00;
	endtask

	function automatic bit ends_with(string pat);
		int n = pat.len();
		if (kept < n)
			return 0;
		for (int k = 0; k < n; k++)
			if (recent[TAIL_DEPTH - n + k] != pat[k])
				return 0;
		return 1;
	endfunction

	task automatic take_char(logic [7:0] c);
		if (!ended && c == 8'h00)
			ended = 1;
		if (ended || kept >= MAX_KEPT)
			return;
		// /etc/p shares the first rule slot
		for (int r = 0; r < 8; r++)
			if (kept < prefix_rules[r].len() && c != prefix_rules[r][kept] &&
			    !(r == 0 && kept == 5 && c == "p"))
				alive[r] = 1'b0;
		for (int i = 0; i < TAIL_DEPTH - 1; i++)
			recent[i] = recent[i + 1];
		recent[TAIL_DEPTH - 1] = c;
		kept++;
	endtask

	function automatic path_verdict_t judge(logic [1:0] mode);
		path_verdict_t v;
		v.kind = HIT_NONE;
		for (int r = 0; r < 8; r++)
			if (alive[r] && kept >= prefix_rules[r].len())
				v.kind = HIT_PREFIX;
		if (v.kind == HIT_NONE && mode != 2'b00) begin
			if (ends_with(tail_pats[0]))
				v.kind = HIT_RELEASE;
			else if (ends_with(tail_pats[1]))
				v.kind = HIT_NOTIFY;
		end
		v.report = (v.kind != HIT_NONE);
		v.length = (kept > 255) ? 8'd255 : 8'(kept);
		return v;
	endfunction

	initial begin
		clear_path();
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_path();
			verdict_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					$error("verdict word with none expected: report %0d kind %0d length %0d",
						report, hit_kind, path_length);
					failures++;
				end else begin
					want = verdict_q.pop_front();
					if (report !== want.report) begin
						$error("report: expected %0d, got %0d", want.report, report);
						failures++;
					end
					if (hit_kind !== want.kind) begin
						$error("hit_kind: expected %0d, got %0d", want.kind, hit_kind);
						failures++;
					end
					if (path_length !== want.length) begin
						$error("path_length: expected %0d, got %0d", want.length, path_length);
						failures++;
					end
				end
			end
			if (in_valid && in_ready) begin
				take_char(path_byte);
				if (is_last) begin
					verdict_q.push_back(judge(access_mode));
					clear_path();
				end
			end
		end
		pending = verdict_q.size();
	end

endmodule

`default_nettype wire

>>> tb/sensitive_path_filter_test.sv
// sensitive_path_filter_test: drives directed and random file paths into sensitive_path_filter
// with bursty input, a stalling receiver and one long output hold-off
// depends on sensitive_path_filter, spf_pkg and spf_checker
`default_nettype none

module sensitive_path_filter_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int WORD_TARGET = 750;
	localparam int HOLD_CYCLES = 150;

	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_RDWR  = 2'd2;
	localparam logic [1:0] MODE_BOTH  = 2'd3;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] path_byte;
	logic       is_last;
	logic [1:0] access_mode;
	logic       out_valid;
	logic       out_ready;
	logic       report;
	logic [1:0] hit_kind;
	logic [7:0] path_length;
	int         fail_count;
	int         verdicts_waiting;

	bit         long_hold = 0;
	int         words_sent = 0;
	int         burst_left = 0;
	int         cycles = 0;
	logic [7:0] chars [$];

	string hot_prefixes [9] = '{"/etc/s", "/etc/p", "/proc/k", "/var/run/d", "/run/d",
		"/proc/self/exe", "/proc/self/mem", "/proc/self/cmdline", "/host_"};
	string tails [2] = '{{"release", "_agent"}, {"notify_on", "_release"}};

	sensitive_path_filter i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.path_byte   (path_byte),
		.is_last     (is_last),
		.access_mode (access_mode),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.report      (report),
		.hit_kind    (hit_kind),
		.path_length (path_length)
	);

	spf_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.path_byte        (path_byte),
		.is_last          (is_last),
		.access_mode      (access_mode),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.report           (report),
		.hit_kind         (hit_kind),
		.path_length      (path_length),
		.fail_count       (fail_count),
		.verdicts_waiting (verdicts_waiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	// receiver: rotating stall styles, plus one long hold-off on request
	initial begin
		int rx_cycle;
		rx_cycle = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 0;
			end else begin
				case ((rx_cycle / 64) % 4)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ((rx_cycle % 7) < 3);
				endcase
			end
		end
	end

	task automatic send_word(logic [7:0] b, logic last, logic [1:0] mode);
		@(negedge clk);
		in_valid <= 1'b1;
		path_byte <= b;
		is_last <= last;
		access_mode <= mode;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic rest_input(int n);
		@(negedge clk);
		in_valid <= 1'b0;
		path_byte <= 8'($urandom);
		is_last <= 1'($urandom);
		access_mode <= 2'($urandom);
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_path(logic [1:0] mode);
		for (int i = 0; i < chars.size(); i++) begin
			if (burst_left == 0) begin
				rest_input($urandom_range(1, 6));
				burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 20);
			end
			burst_left--;
			if (i == chars.size() - 1)
				send_word(chars[i], 1'b1, mode);
			else
				send_word(chars[i], 1'b0, 2'($urandom));
		end
		chars.delete();
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			chars.push_back(s[i]);
	endtask

	task automatic add_noise(int n, bit printable);
		repeat (n)
			chars.push_back(printable ? 8'($urandom_range(33, 126)) : 8'($urandom));
	endtask

	task automatic drain();
		rest_input(1);
		while (verdicts_waiting != 0)
			@(negedge clk);
	endtask

	initial begin
		int    style;
		int    pick;
		int    cut;
		string s;
		logic [1:0] mode;

		arst_n = 1'b0;
		in_valid = 1'b0;
		path_byte = 8'h00;
		is_last = 1'b0;
		access_mode = MODE_READ;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// receiver holds off while the first paths stream in
		long_hold = 1;

		// directed paths
		foreach (hot_prefixes[i]) begin
			add_text(hot_prefixes[i]);
			add_noise(i % 3, 1'b1);
			send_path(MODE_READ);
		end
		add_text("/proc/self/cm");
		send_path(MODE_BOTH);
		add_text("/etc/x");
		send_path(MODE_WRITE);
		add_text("/sys/fs/cgroup/");
		add_text(tails[0]);
		send_path(MODE_WRITE);
		add_text("/sys/fs/cgroup/");
		add_text(tails[0]);
		send_path(MODE_READ);
		add_text("/sys/fs/cgroup/x/");
		add_text(tails[1]);
		send_path(MODE_RDWR);
		add_text(tails[1]);
		send_path(MODE_BOTH);
		add_text("/host_/");
		add_text(tails[0]);
		send_path(MODE_WRITE);
		chars.push_back(8'h00);
		send_path(MODE_BOTH);
		chars.push_back(8'hff);
		send_path(MODE_BOTH);
		add_text("/etc/s");
		chars.push_back(8'h00);
		add_text("zz");
		send_path(MODE_READ);
		add_text(tails[0]);
		chars.push_back(8'h00);
		add_text("/x");
		send_path(MODE_WRITE);
		// tail lands on the last kept character, the extra one is dropped
		add_noise(242, 1'b1);
		add_text(tails[0]);
		add_text("x");
		send_path(MODE_RDWR);
		drain();

		// random paths
		while (words_sent < WORD_TARGET) begin
			mode = 2'($urandom);
			style = ($urandom_range(0, 29) == 0) ? 9 : $urandom_range(0, 8);
			pick = $urandom_range(0, 8);
			case (style)
				0, 1, 2: begin
					add_text(hot_prefixes[pick]);
					add_noise($urandom_range(0, 10), 1'b1);
				end
				3: begin
					s = hot_prefixes[pick];
					cut = $urandom_range(1, s.len() - 1);
					if ($urandom_range(0, 1))
						s = s.substr(0, cut - 1);
					else
						s[cut] = s[cut] ^ 8'h01;
					add_text(s);
					add_noise($urandom_range(0, 6), 1'b1);
				end
				4, 5: begin
					s = tails[$urandom_range(0, 1)];
					if ($urandom_range(0, 3) == 0) begin
						cut = $urandom_range(0, s.len() - 1);
						s[cut] = s[cut] ^ 8'h20;
					end
					add_noise($urandom_range(0, 12), 1'b1);
					if ($urandom_range(0, 1))
						add_text("/");
					add_text(s);
					if ($urandom_range(0, 3) != 0)
						mode = 2'($urandom_range(1, 3));
				end
				6: add_noise($urandom_range(1, 20), 1'b0);
				7: begin
					if ($urandom_range(0, 1))
						add_text(hot_prefixes[pick]);
					else
						add_text(tails[$urandom_range(0, 1)]);
					add_noise($urandom_range(0, 4), 1'b1);
					chars.insert($urandom_range(0, chars.size()), 8'h00);
				end
				8: add_noise($urandom_range(1, 30), 1'b1);
				default: begin
					add_noise($urandom_range(236, 250), 1'b1);
					add_text(tails[$urandom_range(0, 1)]);
					add_noise($urandom_range(0, 3), 1'b1);
					mode = MODE_BOTH;
				end
			endcase
			send_path(mode);
		end

		drain();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && verdicts_waiting == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
